[rtl/core/moving_average_iir_filter_top_macros.svh]
// ----------------------------------------------------------------------------
// moving_average_iir_filter_top_macros.svh
// assertion macros shared by the filter rtl, empty for synthesis
// ----------------------------------------------------------------------------
`ifndef MOVING_AVERAGE_IIR_FILTER_TOP_MACROS_SVH
`define MOVING_AVERAGE_IIR_FILTER_TOP_MACROS_SVH

`ifndef SYNTHESIS

// clocked check, switched off while reset is asserted
`define MAIF_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also holds while reset is asserted
`define MAIF_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define MAIF_ASSERT(label, prop, msg)

`define MAIF_ASSERT_RST(label, prop, msg)

`endif

`endif

[rtl/core/maif_pkg.sv]
// ----------------------------------------------------------------------------
// maif_pkg
// widths, reset values and register map of the moving average / iir filter
// ----------------------------------------------------------------------------
package maif_pkg;

    // payload widths
    localparam int SAMPLE_W   = 16;
    localparam int ALPHA_W    = 16;
    localparam int OUT_W      = 32;

    // fixed point formats
    localparam int AVG_FRAC_W = 3;   // fraction bits kept by the boxcar average
    localparam int OUT_FRAC_W = 16;  // q16.16 output

    // default window length
    localparam int WINDOW_LEN_DEFAULT = 8;

    // configuration port
    localparam int CFG_DATA_W = 32;
    localparam int REG_IDX_W  = 1;
    localparam int CFG_ADDR_W = REG_IDX_W + 2;

    localparam logic [REG_IDX_W-1:0] REG_ALPHA = REG_IDX_W'(0);

    // about 0.385 in q0.16
    localparam logic [ALPHA_W-1:0] ALPHA_RESET = ALPHA_W'(25231);

endpackage

[rtl/core/maif_ram.sv]
// ----------------------------------------------------------------------------
// maif_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
module maif_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/core/moving_average_iir_filter_top.sv]
// ----------------------------------------------------------------------------
// moving_average_iir_filter_top
// boxcar average of the last WINDOW_LEN adc samples followed by a first
// order iir smoother, q16.16 output
// ----------------------------------------------------------------------------
// Each accepted sample gives exactly one filtered result, in order. The block
// takes one sample per clock cycle for as long as results are taken. A
// sample passes the stages in order: its transfer updates the window ram and
// the running sum, then the average is registered with three fraction bits,
// and then the iir multiply-accumulate against the previous output loads the
// output register, where the result is offered. That last stage closes the
// only feedback loop (one 16 x 33 bit multiply and an add per cycle), which
// is what fixes the rate at one sample per cycle. The window sits in a ram
// whose oldest entry is prefetched while the ring pointer moves, so no
// clearing pass runs after reset: until the ring has wrapped once, evicted
// samples read as zero. The weight alpha_reg (unsigned q0.16, reset 25231,
// about 0.385) is written at byte address 0 of the apb port; the user must
// write it only while no sample is in flight, the block does not enforce it.
// The previous output keeps a weight of (65536 - alpha) / 65536.
// ----------------------------------------------------------------------------
`include "moving_average_iir_filter_top_macros.svh"

module moving_average_iir_filter_top #(
    parameter int WINDOW_LEN = maif_pkg::WINDOW_LEN_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,

    // configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [maif_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [maif_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [maif_pkg::CFG_DATA_W-1:0] prdata,
    output logic                            pready,

    // sample channel
    input  logic                            sample_valid,
    output logic                            sample_stall,
    input  logic [maif_pkg::SAMPLE_W-1:0]   sample,

    // result channel
    output logic                            filtered_valid,
    input  logic                            filtered_stall,
    output logic [maif_pkg::OUT_W-1:0]      filtered
);

    // ------------------------------------------------------------------
    // derived sizes
    // ------------------------------------------------------------------
    localparam int SLOT_W    = $clog2(WINDOW_LEN);
    localparam int SUM_W     = maif_pkg::SAMPLE_W + SLOT_W;        // running sum
    localparam int NUM_W     = SUM_W + maif_pkg::AVG_FRAC_W;       // sum with fraction bits
    localparam int AVG_W     = maif_pkg::SAMPLE_W + maif_pkg::AVG_FRAC_W;
    localparam int AVG_ALIGN = maif_pkg::OUT_FRAC_W - maif_pkg::AVG_FRAC_W;
    localparam int OUT_W     = maif_pkg::OUT_W;
    localparam int ALPHA_W   = maif_pkg::ALPHA_W;
    localparam int PROD_W    = OUT_W + ALPHA_W + 2;                // signed mix product
    localparam int STEP_W    = OUT_W + 2;                          // correction term

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW_LEN - 1);
    localparam bit IS_POW2 = ((WINDOW_LEN & (WINDOW_LEN - 1)) == 0);

    // ------------------------------------------------------------------
    // configuration register
    // ------------------------------------------------------------------
    logic [ALPHA_W-1:0]             alpha_reg;
    logic [maif_pkg::REG_IDX_W-1:0] reg_idx;
    logic                           cfg_write;

    assign pready    = 1'b1;
    assign reg_idx   = paddr[maif_pkg::CFG_ADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg <= maif_pkg::ALPHA_RESET;
        end
        else if (cfg_write && (reg_idx == maif_pkg::REG_ALPHA))
        begin
            alpha_reg <= pwdata[ALPHA_W-1:0];
        end
    end

    // register read-back, writes beyond the map are dropped
    always_comb
    begin
        unique case (reg_idx)
            maif_pkg::REG_ALPHA: prdata = maif_pkg::CFG_DATA_W'(alpha_reg);
            default:             prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // pipeline flow control
    // a stage loads when the one after it is empty or moving on, so a
    // sample is still taken while a finished result waits downstream
    // ------------------------------------------------------------------
    logic s1_valid_reg;
    logic s2_valid_reg;
    logic out_valid_reg;
    logic s1_en;
    logic s2_en;
    logic out_en;
    logic accept;
    logic out_load;

    assign out_en       = !out_valid_reg || !filtered_stall;
    assign s2_en        = !s2_valid_reg || out_en;
    assign s1_en        = !s1_valid_reg || s2_en;
    assign sample_stall = !s1_en;
    assign accept       = sample_valid && s1_en;
    assign out_load     = out_en && s2_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_en)
            begin
                s1_valid_reg <= accept;
            end
            if (s2_en)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (out_en)
            begin
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    // ------------------------------------------------------------------
    // window ring and running sum, updated on each sample transfer
    // ------------------------------------------------------------------
    logic [SLOT_W-1:0]            slot_reg;
    logic [SLOT_W-1:0]            slot_next;
    logic [SLOT_W-1:0]            rd_slot;
    logic                         wrap_now;          // transfer into the last slot
    logic                         window_full_reg;   // ring has wrapped at least once
    logic [maif_pkg::SAMPLE_W-1:0] oldest_data;
    logic [maif_pkg::SAMPLE_W-1:0] evicted;
    logic [SUM_W-1:0]             sum_reg;
    logic [SUM_W-1:0]             sum_next;

    assign slot_next = (slot_reg == LAST_SLOT) ? '0 : slot_reg + SLOT_W'(1);
    assign wrap_now  = accept && (slot_reg == LAST_SLOT);

    // prefetch the entry that the next sample will overwrite
    assign rd_slot = accept ? slot_next : slot_reg;

    maif_ram #(
        .WIDTH (maif_pkg::SAMPLE_W),
        .DEPTH (WINDOW_LEN)
    ) u_window_ram (
        .clk     (clk),
        .wr_en   (accept),
        .wr_addr (slot_reg),
        .wr_data (sample),
        .rd_addr (rd_slot),
        .rd_data (oldest_data)
    );

    // until the ring has wrapped, entries not yet written count as zero
    assign evicted  = window_full_reg ? oldest_data : '0;
    assign sum_next = sum_reg + SUM_W'(sample) - SUM_W'(evicted);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg        <= '0;
            window_full_reg <= 1'b0;
            sum_reg         <= '0;
        end
        else if (accept)
        begin
            slot_reg <= slot_next;
            sum_reg  <= sum_next;
            if (wrap_now)
            begin
                window_full_reg <= 1'b1;
            end
        end
    end

    // stage 1 payload: window sum after this sample
    logic [SUM_W-1:0] s1_sum_reg;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_sum_reg <= sum_next;
        end
    end

    // ------------------------------------------------------------------
    // stage 2: boxcar average with three fraction bits
    // ------------------------------------------------------------------
    logic [NUM_W-1:0] s1_num;
    logic [AVG_W-1:0] s1_avg;
    logic [AVG_W-1:0] s2_avg_reg;

    assign s1_num = {s1_sum_reg, maif_pkg::AVG_FRAC_W'(0)};

    generate
        if (IS_POW2)
        begin : g_shift
            // power of two window, the division is a plain shift
            assign s1_avg = s1_num[SLOT_W +: AVG_W];
        end
        else
        begin : g_recip
            // exact floor division by multiplying with a rounded-up reciprocal
            localparam int RECIP_SHIFT = NUM_W + SLOT_W;
            localparam int RECIP_W     = NUM_W + 1;
            localparam logic [63:0] RECIP_FULL =
                ((64'd1 << RECIP_SHIFT) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN);
            localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];

            logic [NUM_W+RECIP_W-1:0] quot_prod;

            assign quot_prod = s1_num * RECIP;
            assign s1_avg    = quot_prod[RECIP_SHIFT +: AVG_W];
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (s2_en && s1_valid_reg)
        begin
            s2_avg_reg <= s1_avg;
        end
    end

    // ------------------------------------------------------------------
    // stage 3: iir, out = prev + floor(alpha * (avg - prev) / 2^16)
    // the output register doubles as the previous output
    // ------------------------------------------------------------------
    logic [OUT_W-1:0]         avg_q16;
    logic [OUT_W-1:0]         out_reg;
    logic signed [OUT_W:0]    mix_diff;
    logic signed [PROD_W-1:0] mix_prod;
    logic signed [STEP_W-1:0] mix_step;
    logic [STEP_W-1:0]        mix_sum;

    assign avg_q16  = {s2_avg_reg, AVG_ALIGN'(0)};
    assign mix_diff = $signed({1'b0, avg_q16}) - $signed({1'b0, out_reg});
    assign mix_prod = mix_diff * $signed({1'b0, alpha_reg});
    assign mix_step = mix_prod[PROD_W-1:ALPHA_W];
    assign mix_sum  = {2'b00, out_reg} + $unsigned(mix_step);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_reg <= '0;
        end
        else if (out_load)
        begin
            out_reg <= mix_sum[OUT_W-1:0];
        end
    end

    assign filtered_valid = out_valid_reg;
    assign filtered       = out_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `MAIF_ASSERT_RST(a_reset_idle, !rst_n |=> !(filtered_valid || sample_stall), "busy after reset")
    `MAIF_ASSERT(a_slot_wrap, wrap_now |=> (slot_reg == '0), "ring pointer did not wrap")
    `MAIF_ASSERT(a_sum_hold, !accept |=> $stable(sum_reg), "sum moved without a transfer")
    `MAIF_ASSERT(a_prev_hold, !out_load |=> $stable(out_reg), "output moved without a load")
    `MAIF_ASSERT(a_full_sticky, window_full_reg |=> window_full_reg, "full flag cleared")

endmodule
